// ===== rtl/dmacc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmacc_pkg;

    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_BURST_BEATS = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int MAX_RESULTS     = 16;

    localparam logic [31:0] WIN_BASE    = 32'h4B00_0000;
    localparam int          CTRL_STRIDE = 64;

    // Register offsets within a channel
    localparam logic [5:0] OFF_SSRC = 6'h00;
    localparam logic [5:0] OFF_SCTL = 6'h04;
    localparam logic [5:0] OFF_DST  = 6'h08;
    localparam logic [5:0] OFF_DCTL = 6'h0C;
    localparam logic [5:0] OFF_CON  = 6'h10;
    localparam logic [5:0] OFF_CNT  = 6'h14;
    localparam logic [5:0] OFF_CSRC = 6'h18;
    localparam logic [5:0] OFF_CDST = 6'h1C;
    localparam logic [5:0] OFF_TRIG = 6'h20;

    // Request types on the bus
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_HW    = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_BAD_REG  = 3'd1;
    localparam logic [2:0] ERR_RSV_SIZE = 3'd2;
    localparam logic [2:0] ERR_BAD_SEL  = 3'd3;
    localparam logic [2:0] ERR_WHOLE_HW = 3'd4;
    localparam logic [2:0] ERR_WINDOW   = 3'd5;

    // Control word bits
    localparam int CON_INT    = 29;
    localparam int CON_TSZ    = 28;
    localparam int CON_SERV   = 27;
    localparam int CON_SWHW   = 23;
    localparam int CON_RELOAD = 22;
    localparam logic [2:0] SEL_MAX = 3'd4;
    localparam logic [1:0] DSZ_RSV = 2'd3;

    typedef enum logic [2:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_REQ   = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_BAD   = 3'd4
    } cmd_kind_t;

    typedef enum logic [3:0] {
        REG_SSRC = 4'd0,
        REG_SCTL = 4'd1,
        REG_DST  = 4'd2,
        REG_DCTL = 4'd3,
        REG_CON  = 4'd4,
        REG_CNT  = 4'd5,
        REG_CSRC = 4'd6,
        REG_CDST = 4'd7,
        REG_TRIG = 4'd8,
        REG_NONE = 4'd9
    } reg_sel_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  ch;
        reg_sel_t    reg_sel;
        logic [31:0] data;
        logic [3:0]  src;
    } cmd_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        beat_valid;
        logic [30:0] source_address;
        logic [30:0] dest_address;
        logic [1:0]  unit_size_log2;
        logic        irq_valid;
        logic [1:0]  irq_channel;
        logic        armed_valid;
        logic [3:0]  armed_source;
        logic [2:0]  error_code;
        logic        last;
    } res_t;

    function automatic logic [3:0] src_lookup(input logic [1:0] row, input logic [2:0] sel);
        logic [3:0] v;
        v = 4'd0;
        case (row)
            2'd0: case (sel)
                3'd0: v = 4'd0;  3'd1: v = 4'd2;  3'd2: v = 4'd5;
                3'd3: v = 4'd6;  3'd4: v = 4'd7;  default: v = 4'd0;
            endcase
            2'd1: case (sel)
                3'd0: v = 4'd1;  3'd1: v = 4'd3;  3'd2: v = 4'd12;
                3'd3: v = 4'd13; 3'd4: v = 4'd8;  default: v = 4'd0;
            endcase
            2'd2: case (sel)
                3'd0: v = 4'd11; 3'd1: v = 4'd12; 3'd2: v = 4'd5;
                3'd3: v = 4'd6;  3'd4: v = 4'd9;  default: v = 4'd0;
            endcase
            default: case (sel)
                3'd0: v = 4'd4;  3'd1: v = 4'd5;  3'd2: v = 4'd14;
                3'd3: v = 4'd6;  3'd4: v = 4'd10; default: v = 4'd0;
            endcase
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dma_channel_controller_core.sv =====
// A read passes through S_IDLE, S_SINGLE and S_FINISH, a write through S_IDLE, S_WRITE,
// S_ARM and S_FINISH, and a write whose software trigger starts a transfer also runs it.
// A request or tick visits each channel in turn (S_REQ or S_TICK), then S_FINISH, and
// runs each atomic transfer through S_LOAD (request only), S_CHECK, S_BEAT and S_UPD.
// Items are served one at a time; a two-entry command queue lets the front accept
// while the back is busy. Output stalls hold the back end.
// Reset clears every channel register at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dma_channel_controller_core
    import dmacc_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int BURST_BEATS = DEF_BURST_BEATS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  bus_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [3:0]  request_source,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic             beat_valid,
    output logic [30:0]      source_address,
    output logic [30:0]      dest_address,
    output logic [1:0]       unit_size_log2,
    output logic             irq_valid,
    output logic [1:0]       irq_channel,
    output logic             armed_valid,
    output logic [3:0]       armed_source,
    output logic [2:0]       error_code,
    output logic             last
);

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push_valid, push_ready, pop_valid, pop_ready;
    res_t res;

    dmacc_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .bus_offset     (bus_offset),
        .write_data     (write_data),
        .request_source (request_source),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    dmacc_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    dmacc_back #(
        .CHANNELS    (CHANNELS),
        .BURST_BEATS (BURST_BEATS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_cmd     (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign read_data      = res.read_data;
    assign beat_valid     = res.beat_valid;
    assign source_address = res.source_address;
    assign dest_address   = res.dest_address;
    assign unit_size_log2 = res.unit_size_log2;
    assign irq_valid      = res.irq_valid;
    assign irq_channel    = res.irq_channel;
    assign armed_valid    = res.armed_valid;
    assign armed_source   = res.armed_source;
    assign error_code     = res.error_code;
    assign last           = res.last;

    a_irq_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_valid |-> beat_valid && error_code == ERR_OK)
        else $error("interrupt without a clean beat");

    a_arm_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && armed_valid |-> !beat_valid && error_code == ERR_OK)
        else $error("armed word carries a beat or an error");

    a_beat_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beat_valid |-> unit_size_log2 != DSZ_RSV)
        else $error("beat with reserved size");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> !pop_ready)
        else $error("command taken while back end busy");

endmodule

`default_nettype wire

// ===== rtl/dmacc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmacc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             push, pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmacc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmacc_front
    import dmacc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  bus_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [3:0]  request_source,
    output logic             push_valid,
    input  wire logic        push_ready,
    output cmd_t             push_cmd
);

    reg_sel_t sel;
    logic     ch_bad;
    logic     ro_write;

    assign ch_bad = (int'(bus_offset[7:6]) >= CHANNELS);

    always_comb
    begin
        case (bus_offset[5:0])
            OFF_SSRC: sel = REG_SSRC;
            OFF_SCTL: sel = REG_SCTL;
            OFF_DST:  sel = REG_DST;
            OFF_DCTL: sel = REG_DCTL;
            OFF_CON:  sel = REG_CON;
            OFF_CNT:  sel = REG_CNT;
            OFF_CSRC: sel = REG_CSRC;
            OFF_CDST: sel = REG_CDST;
            OFF_TRIG: sel = REG_TRIG;
            default:  sel = REG_NONE;
        endcase
    end

    assign ro_write = (sel == REG_CNT) || (sel == REG_CSRC) || (sel == REG_CDST);

    // Classify the word; bad register accesses are settled here
    always_comb
    begin
        push_cmd.ch      = bus_offset[7:6];
        push_cmd.reg_sel = sel;
        push_cmd.data    = write_data;
        push_cmd.src     = request_source;
        case (req_type)
            REQ_READ:  push_cmd.kind = (ch_bad || sel == REG_NONE) ? CMD_BAD : CMD_READ;
            REQ_WRITE: push_cmd.kind = (ch_bad || sel == REG_NONE || ro_write)
                                       ? CMD_BAD : CMD_WRITE;
            REQ_HW:    push_cmd.kind = CMD_REQ;
            default:   push_cmd.kind = CMD_TICK;
        endcase
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

`default_nettype wire

// ===== rtl/dmacc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmacc_back
    import dmacc_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int BURST_BEATS = DEF_BURST_BEATS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BW  = $clog2(BURST_BEATS + 1);
    localparam logic [31:0] WIN_SPAN = 32'(CHANNELS * CTRL_STRIDE);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SINGLE = 11'b000_0000_0010,
        S_WRITE  = 11'b000_0000_0100,
        S_ARM    = 11'b000_0000_1000,
        S_REQ    = 11'b000_0001_0000,
        S_TICK   = 11'b000_0010_0000,
        S_LOAD   = 11'b000_0100_0000,
        S_CHECK  = 11'b000_1000_0000,
        S_BEAT   = 11'b001_0000_0000,
        S_UPD    = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } state_t;

    function automatic logic in_win(input logic [31:0] a);
        return (a >= WIN_BASE) && ((a - WIN_BASE) < WIN_SPAN);
    endfunction

    state_t state_reg, state_next;
    logic   next_ch;

    logic [30:0] ssrc_reg [CHANNELS], ssrc_next [CHANNELS];
    logic [1:0]  sctl_reg [CHANNELS], sctl_next [CHANNELS];
    logic [30:0] sdst_reg [CHANNELS], sdst_next [CHANNELS];
    logic [1:0]  dctl_reg [CHANNELS], dctl_next [CHANNELS];
    logic [31:0] ctl_reg  [CHANNELS], ctl_next  [CHANNELS];
    logic [19:0] cnt_reg  [CHANNELS], cnt_next  [CHANNELS];
    logic [31:0] csrc_reg [CHANNELS], csrc_next [CHANNELS];
    logic [31:0] cdst_reg [CHANNELS], cdst_next [CHANNELS];
    logic [2:0]  trig_reg [CHANNELS], trig_next [CHANNELS];
    logic        pend_reg [CHANNELS], pend_next [CHANNELS];

    cmd_t          cmd_reg, cmd_next;
    logic [CHW-1:0] ch_reg, ch_next;
    logic [BW-1:0]  beat_reg, beat_next;
    logic           was_on_reg, was_on_next;
    logic [4:0]     res_cnt_reg, res_cnt_next;
    res_t           hold_reg, hold_next;
    logic           hold_valid_reg, hold_valid_next;
    res_t           out_res_reg, out_res_next;
    logic           out_valid_reg, out_valid_next;

    // Selected channel view
    logic [31:0] con_w, csrc_w, cdst_w, off_w, step_w, sa_w, da_w;
    logic [19:0] cnt_w, newtc_w, load_cnt_w;
    logic [2:0]  trig_w, sel_w, tdata_w, tnew_w;
    logic [1:0]  dsz_w;
    logic [BW-1:0] beats_w;
    logic [3:0]  tbl_w;
    logic on_w, swhw_w, serv_w, sel_bad_w, last_beat_w, irq_w, win_hit_w;

    logic put_en, out_free, cnt_full, go;
    res_t put_res;

    assign con_w     = ctl_reg[ch_reg];
    assign csrc_w    = csrc_reg[ch_reg];
    assign cdst_w    = cdst_reg[ch_reg];
    assign cnt_w     = cnt_reg[ch_reg];
    assign trig_w    = trig_reg[ch_reg];
    assign dsz_w     = con_w[21:20];
    assign beats_w   = con_w[CON_TSZ] ? BW'(BURST_BEATS) : BW'(1);
    assign on_w      = trig_w[1];
    assign swhw_w    = con_w[CON_SWHW];
    assign serv_w    = con_w[CON_SERV];
    assign sel_w     = con_w[26:24];
    assign sel_bad_w = (sel_w > SEL_MAX);
    assign tbl_w     = src_lookup(2'(ch_reg), sel_w);
    assign off_w     = 32'(beat_reg) << dsz_w;
    assign step_w    = 32'(beats_w) << dsz_w;
    assign sa_w      = csrc_w + off_w;
    assign da_w      = cdst_w + off_w;
    assign win_hit_w = in_win(sa_w) || in_win(da_w);
    assign newtc_w   = cnt_w - 20'd1;
    assign irq_w     = (newtc_w == 20'd0) && con_w[CON_INT];
    assign last_beat_w = (beat_reg == beats_w - BW'(1));
    assign load_cnt_w  = (cnt_w == 20'd0) ? con_w[19:0] : cnt_w;
    assign tdata_w   = cmd_reg.data[2:0];
    assign tnew_w    = {tdata_w[2], tdata_w[1] && !tdata_w[2], 1'b0};
    assign next_ch   = (ch_reg == CHW'(CHANNELS - 1));

    // Result produced by the current step, if any
    always_comb
    begin
        put_en  = 1'b0;
        put_res = '0;
        case (state_reg)
            S_SINGLE:
            begin
                put_en = 1'b1;
                if (cmd_reg.kind == CMD_BAD)
                begin
                    put_res.error_code = ERR_BAD_REG;
                end
                else
                begin
                    case (cmd_reg.reg_sel)
                        REG_SSRC: put_res.read_data = {1'b0, ssrc_reg[ch_reg]};
                        REG_SCTL: put_res.read_data = {30'd0, sctl_reg[ch_reg]};
                        REG_DST:  put_res.read_data = {1'b0, sdst_reg[ch_reg]};
                        REG_DCTL: put_res.read_data = {30'd0, dctl_reg[ch_reg]};
                        REG_CON:  put_res.read_data = con_w;
                        REG_CNT:  put_res.read_data = {12'd0, cnt_w};
                        REG_CSRC: put_res.read_data = {1'b0, csrc_w[30:0]};
                        REG_CDST: put_res.read_data = {1'b0, cdst_w[30:0]};
                        REG_TRIG: put_res.read_data = {29'd0, trig_w};
                        default:  put_res.read_data = '0;
                    endcase
                end
            end
            S_ARM:
            begin
                if (!was_on_reg && on_w && swhw_w)
                begin
                    put_en = 1'b1;
                    if (sel_bad_w)
                    begin
                        put_res.error_code = ERR_BAD_SEL;
                    end
                    else
                    begin
                        put_res.armed_valid  = 1'b1;
                        put_res.armed_source = tbl_w;
                    end
                end
            end
            S_REQ:
            begin
                if (on_w && swhw_w)
                begin
                    if (sel_bad_w)
                    begin
                        put_en = 1'b1;
                        put_res.error_code = ERR_BAD_SEL;
                    end
                    else if (tbl_w == cmd_reg.src && serv_w)
                    begin
                        put_en = 1'b1;
                        put_res.error_code = ERR_WHOLE_HW;
                    end
                end
            end
            S_CHECK:
            begin
                if (dsz_w == DSZ_RSV)
                begin
                    put_en = 1'b1;
                    put_res.error_code = ERR_RSV_SIZE;
                end
                else if (win_hit_w)
                begin
                    put_en = 1'b1;
                    put_res.error_code = ERR_WINDOW;
                end
            end
            S_BEAT:
            begin
                put_en = 1'b1;
                put_res.beat_valid     = 1'b1;
                put_res.source_address = sa_w[30:0];
                put_res.dest_address   = da_w[30:0];
                put_res.unit_size_log2 = dsz_w;
                put_res.irq_valid      = last_beat_w && irq_w;
                put_res.irq_channel    = irq_w ? 2'(ch_reg) : 2'd0;
            end
            default:
            begin
                put_en = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign cnt_full = (res_cnt_reg == 5'(MAX_RESULTS));
    assign go       = (state_reg == S_FINISH) ? out_free
                    : (!put_en || cnt_full || !hold_valid_reg || out_free);
    assign q_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ssrc_next       = ssrc_reg;
        sctl_next       = sctl_reg;
        sdst_next       = sdst_reg;
        dctl_next       = dctl_reg;
        ctl_next        = ctl_reg;
        cnt_next        = cnt_reg;
        csrc_next       = csrc_reg;
        cdst_next       = cdst_reg;
        trig_next       = trig_reg;
        pend_next       = pend_reg;
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        beat_next       = beat_reg;
        was_on_next     = was_on_reg;
        res_cnt_next    = res_cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_res_next    = out_res_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (go)
        begin
            // Hold the newest result back until the next one shows whether it is last
            if (put_en && !cnt_full)
            begin
                if (hold_valid_reg)
                begin
                    out_res_next   = hold_reg;
                    out_valid_next = 1'b1;
                end
                hold_next       = put_res;
                hold_valid_next = 1'b1;
                res_cnt_next    = res_cnt_reg + 5'd1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_next = q_cmd;
                        case (q_cmd.kind)
                            CMD_WRITE:
                            begin
                                ch_next    = CHW'(q_cmd.ch);
                                state_next = S_WRITE;
                            end
                            CMD_REQ:
                            begin
                                ch_next    = '0;
                                state_next = S_REQ;
                            end
                            CMD_TICK:
                            begin
                                ch_next    = '0;
                                state_next = S_TICK;
                            end
                            default:
                            begin
                                ch_next    = CHW'(q_cmd.ch);
                                state_next = S_SINGLE;
                            end
                        endcase
                    end
                end
                S_SINGLE:
                begin
                    state_next = S_FINISH;
                end
                S_WRITE:
                begin
                    was_on_next = on_w;
                    state_next  = S_ARM;
                    case (cmd_reg.reg_sel)
                        REG_SSRC: ssrc_next[ch_reg] = cmd_reg.data[30:0];
                        REG_SCTL: sctl_next[ch_reg] = cmd_reg.data[1:0];
                        REG_DST:  sdst_next[ch_reg] = cmd_reg.data[30:0];
                        REG_DCTL: dctl_next[ch_reg] = cmd_reg.data[1:0];
                        REG_CON:  ctl_next[ch_reg]  = cmd_reg.data;
                        REG_TRIG:
                        begin
                            trig_next[ch_reg] = tnew_w;
                            if (tdata_w[2])
                            begin
                                cnt_next[ch_reg]  = '0;
                                pend_next[ch_reg] = 1'b0;
                            end
                            // software trigger on a switched-on software-mode channel
                            if (tdata_w[0] && tnew_w[1] && !swhw_w)
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_ARM;
                        end
                    endcase
                end
                S_ARM:
                begin
                    state_next = S_FINISH;
                end
                S_REQ:
                begin
                    if (on_w && swhw_w && !sel_bad_w && tbl_w == cmd_reg.src && !serv_w)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (next_ch)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ch_next = ch_reg + CHW'(1);
                    end
                end
                S_TICK:
                begin
                    if (pend_reg[ch_reg] && on_w && serv_w && cnt_w != 20'd0)
                    begin
                        beat_next  = '0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        pend_next[ch_reg] = 1'b0;
                        if (next_ch)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ch_next = ch_reg + CHW'(1);
                        end
                    end
                end
                S_LOAD:
                begin
                    if (cnt_w == 20'd0)
                    begin
                        cnt_next[ch_reg]  = con_w[19:0];
                        csrc_next[ch_reg] = {1'b0, ssrc_reg[ch_reg]};
                        cdst_next[ch_reg] = {1'b0, sdst_reg[ch_reg]};
                    end
                    beat_next = '0;
                    if (load_cnt_w == 20'd0)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (dsz_w == DSZ_RSV || win_hit_w)
                    begin
                        pend_next[ch_reg] = 1'b0;
                        state_next = S_UPD;
                    end
                    else if (last_beat_w)
                    begin
                        beat_next  = '0;
                        state_next = S_BEAT;
                    end
                    else
                    begin
                        beat_next = beat_reg + BW'(1);
                    end
                end
                S_BEAT:
                begin
                    if (last_beat_w)
                    begin
                        // mark the commit pass with a full beat index
                        beat_next  = beats_w;
                        state_next = S_UPD;
                    end
                    else
                    begin
                        beat_next = beat_reg + BW'(1);
                    end
                end
                S_UPD:
                begin
                    // only commit after a completed set of beats
                    if (beat_reg == beats_w && beat_reg != '0)
                    begin
                        if (!sctl_reg[ch_reg][0])
                        begin
                            csrc_next[ch_reg] = csrc_w + step_w;
                        end
                        if (!dctl_reg[ch_reg][0])
                        begin
                            cdst_next[ch_reg] = cdst_w + step_w;
                        end
                        cnt_next[ch_reg] = newtc_w;
                        if (newtc_w == 20'd0)
                        begin
                            pend_next[ch_reg] = 1'b0;
                            if (con_w[CON_RELOAD])
                            begin
                                trig_next[ch_reg] = {trig_w[2], 1'b0, trig_w[0]};
                            end
                        end
                        else
                        begin
                            pend_next[ch_reg] = serv_w;
                        end
                    end
                    beat_next = '0;
                    case (cmd_reg.kind)
                        CMD_WRITE:
                        begin
                            state_next = S_ARM;
                        end
                        CMD_REQ, CMD_TICK:
                        begin
                            if (next_ch)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                ch_next    = ch_reg + CHW'(1);
                                state_next = (cmd_reg.kind == CMD_REQ) ? S_REQ : S_TICK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
                S_FINISH:
                begin
                    out_res_next      = hold_valid_reg ? hold_reg : '0;
                    out_res_next.last = 1'b1;
                    out_valid_next    = 1'b1;
                    hold_valid_next   = 1'b0;
                    res_cnt_next      = '0;
                    state_next        = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ssrc_reg[i] <= '0;
                sctl_reg[i] <= '0;
                sdst_reg[i] <= '0;
                dctl_reg[i] <= '0;
                ctl_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                csrc_reg[i] <= '0;
                cdst_reg[i] <= '0;
                trig_reg[i] <= '0;
                pend_reg[i] <= 1'b0;
            end
            cmd_reg        <= '0;
            ch_reg         <= '0;
            beat_reg       <= '0;
            was_on_reg     <= 1'b0;
            res_cnt_reg    <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_res_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ssrc_reg       <= ssrc_next;
            sctl_reg       <= sctl_next;
            sdst_reg       <= sdst_next;
            dctl_reg       <= dctl_next;
            ctl_reg        <= ctl_next;
            cnt_reg        <= cnt_next;
            csrc_reg       <= csrc_next;
            cdst_reg       <= cdst_next;
            trig_reg       <= trig_next;
            pend_reg       <= pend_next;
            cmd_reg        <= cmd_next;
            ch_reg         <= ch_next;
            beat_reg       <= beat_next;
            was_on_reg     <= was_on_next;
            res_cnt_reg    <= res_cnt_next;
            hold_reg       <= hold_next;
            hold_valid_reg <= hold_valid_next;
            out_res_reg    <= out_res_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire
